@@ rtl/epdm_pkg.sv @@
package epdm_pkg;

  localparam int LEN_W = 7;
  localparam int IDX_W = 4;
  localparam int CFG_W = 5;

  localparam logic [1:0] ACT_WRITE_BYTE = 2'd0;
  localparam logic [1:0] ACT_SET_LEN    = 2'd1;
  localparam logic [1:0] ACT_PROBE      = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] entry_index;
    logic [6:0]       byte_position;
    logic [7:0]       byte_value;
    logic [LEN_W-1:0] pattern_length;
    logic             path_last;
  } epdm_in_t;

  typedef struct packed {
    logic             deny;
    logic [IDX_W-1:0] match_index;
  } epdm_out_t;

  // probe beat in its compare cycle
  typedef struct packed {
    logic vld;
    logic cmp_en;
    logic last;
    logic len_ok;
  } epdm_probe_t;

endpackage

@@ rtl/exact_path_denylist_matcher.sv @@
// channel   ports                             beat taken when
// input     start, busy, in_data              start high, busy low
// result    out_valid, out_data               out_valid high (one cycle, no stall)
// config    cfg_valid, cfg_ready, cfg_data    cfg_valid and cfg_ready high
//
// one item per cycle; busy stays low
// a probe beat reads every pattern bank at the current path position; the
// compare follows in the next cycle and feeds the result register, which
// raises out_valid with the verdict for the final path byte
// loads write the banks and length table in their accept cycle
// synchronous active-low reset clears lengths, flags, position and count;
// pattern banks are not cleared
module exact_path_denylist_matcher import epdm_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int MAX_LEN = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             start,
  output logic             busy,
  input  epdm_in_t         in_data,
  // result channel
  output logic             out_valid,
  output epdm_out_t        out_data,
  // configuration channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  logic              accept;
  logic              is_probe;
  logic              entry_ok;
  logic              byte_we;
  logic              len_we;
  logic              cmp_en;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     plen_r, plen_nxt;
  logic [7:0]        value_r, value_nxt;
  epdm_probe_t       probe_r, probe_nxt;
  logic [CFG_W-1:0]  active_r, active_nxt;
  logic [ENTRIES-1:0] mism;

  // no backpressure on any channel
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign accept   = start && !busy;
  assign is_probe = accept && (in_data.action == ACT_PROBE);
  assign entry_ok = 32'(in_data.entry_index) < ENTRIES;
  assign byte_we  = accept && (in_data.action == ACT_WRITE_BYTE) && entry_ok &&
                    (32'(in_data.byte_position) < MAX_LEN);
  assign len_we   = accept && (in_data.action == ACT_SET_LEN) && entry_ok;

  // bytes past the last stored position are not compared
  assign cmp_en = 32'(pos_r) < MAX_LEN;

  always_comb begin
    pos_nxt    = pos_r;
    plen_nxt   = plen_r;
    value_nxt  = value_r;
    probe_nxt  = '0;
    active_nxt = cfg_valid ? cfg_data : active_r;
    if (is_probe) begin
      // position saturates at MAX_LEN so an overlong path never matches
      if (in_data.path_last) begin
        pos_nxt = '0;
      end else if (cmp_en) begin
        pos_nxt = pos_r + 1'b1;
      end
      plen_nxt         = pos_r + 1'b1;
      value_nxt        = in_data.byte_value;
      probe_nxt.vld    = 1'b1;
      probe_nxt.cmp_en = cmp_en;
      probe_nxt.last   = in_data.path_last;
      probe_nxt.len_ok = 32'(pos_r) < (MAX_LEN - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      probe_r  <= '0;
      active_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      probe_r  <= probe_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plen_r  <= plen_nxt;
    value_r <= value_nxt;
  end

  // pattern banks: write on byte loads, read at the path position on probes
  epdm_pattern_store #(
    .ENTRIES (ENTRIES),
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk       (clk),
    .wr_en     (byte_we),
    .wr_entry  (in_data.entry_index),
    .wr_addr   (AW'(in_data.byte_position)),
    .wr_data   (in_data.byte_value),
    .rd_en     (is_probe && cmp_en),
    .rd_addr   (AW'(pos_r)),
    .cmp_value (value_r),
    .mism      (mism)
  );

  // length table, mismatch flags and the verdict register
  epdm_resolve #(
    .ENTRIES (ENTRIES),
    .MAX_LEN (MAX_LEN)
  ) u_resolve (
    .clk          (clk),
    .rst_n        (rst_n),
    .len_we       (len_we),
    .len_entry    (in_data.entry_index),
    .len_value    (in_data.pattern_length),
    .active_count (active_r),
    .probe        (probe_r),
    .path_len     (plen_r),
    .mism         (mism),
    .res_valid    (out_valid),
    .res_data     (out_data)
  );

endmodule

@@ rtl/epdm_ram.sv @@
module epdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/epdm_pattern_store.sv @@
module epdm_pattern_store import epdm_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int MAX_LEN = 80
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_entry,
  input  logic [$clog2(MAX_LEN)-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(MAX_LEN)-1:0] rd_addr,
  input  logic [7:0]                 cmp_value,
  output logic [ENTRIES-1:0]         mism
);

  // one byte-wide bank per entry, all read at the same position
  for (genvar b = 0; b < ENTRIES; b++) begin : g_bank
    logic       bank_we;
    logic [7:0] bank_rdata;

    assign bank_we = wr_en && (32'(wr_entry) == b);

    epdm_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LEN)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (bank_rdata)
    );

    assign mism[b] = (bank_rdata != cmp_value);
  end

endmodule

@@ rtl/epdm_resolve.sv @@
module epdm_resolve import epdm_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int MAX_LEN = 80
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         len_we,
  input  logic [IDX_W-1:0]             len_entry,
  input  logic [LEN_W-1:0]             len_value,
  input  logic [CFG_W-1:0]             active_count,
  input  epdm_probe_t                  probe,
  input  logic [$clog2(MAX_LEN+1)-1:0] path_len,
  input  logic [ENTRIES-1:0]           mism,
  output logic                         res_valid,
  output epdm_out_t                    res_data
);

  localparam int PW  = $clog2(MAX_LEN + 1);
  localparam int CW  = (PW > LEN_W) ? PW : LEN_W;
  localparam int IXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [LEN_W-1:0]   lens_r   [ENTRIES];
  logic [LEN_W-1:0]   lens_nxt [ENTRIES];
  logic [ENTRIES-1:0] flags_r, flags_nxt;
  logic [ENTRIES-1:0] flags_now;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] low;
  logic [IXW-1:0]     hit_idx;
  logic               res_valid_r, res_valid_nxt;
  epdm_out_t          res_data_r, res_data_nxt;

  always_comb begin
    for (int e = 0; e < ENTRIES; e++) begin
      lens_nxt[e] = lens_r[e];
      if (len_we && (32'(len_entry) == e)) begin
        lens_nxt[e] = len_value;
      end
    end
  end

  // lengths checked against the path length; a valid path length is 1..MAX_LEN-1
  always_comb begin
    flags_now = probe.cmp_en ? (flags_r | mism) : flags_r;
    for (int e = 0; e < ENTRIES; e++) begin
      hit[e] = probe.len_ok && (e < 32'(active_count)) && !flags_now[e] &&
               (CW'(lens_r[e]) == CW'(path_len));
    end
    low     = hit & (~hit + 1'b1);
    hit_idx = '0;
    for (int e = 0; e < ENTRIES; e++) begin
      hit_idx = hit_idx | (low[e] ? IXW'(e) : '0);
    end
  end

  always_comb begin
    flags_nxt     = flags_r;
    res_valid_nxt = 1'b0;
    res_data_nxt  = res_data_r;
    if (probe.vld) begin
      flags_nxt = probe.last ? '0 : flags_now;
      if (probe.last) begin
        res_valid_nxt            = 1'b1;
        res_data_nxt.deny        = |hit;
        res_data_nxt.match_index = (|hit) ? IDX_W'(hit_idx) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENTRIES; e++) begin
        lens_r[e] <= '0;
      end
      flags_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      lens_r      <= lens_nxt;
      flags_r     <= flags_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_data_r <= res_data_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_data_r;

endmodule

@@ verif/exact_path_denylist_matcher_tb.sv @@
module exact_path_denylist_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import epdm_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int PATH_MAX = 80;        // shortest path length that can never match
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;   // cycles without any handshake before giving up
  localparam int SETTLE_CYCLES = 4;    // settle time after every beat is taken and every verdict seen

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  epdm_in_t in_data = '0;
  logic out_valid;
  epdm_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  exact_path_denylist_matcher #(
    .ENTRIES(NUM_ENTRIES),
    .MAX_LEN(PATH_MAX)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // beats waiting to be driven, and verdicts waiting to come out
  epdm_in_t beat_q [$];
  epdm_out_t verdict_q [$];

  // predicted table contents, tracked at the moment each beat is taken
  logic [7:0] pat_mem [NUM_ENTRIES][PATH_MAX];
  logic [LEN_W-1:0] pat_len [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] miss_flags;
  int unsigned path_pos;
  logic [CFG_W-1:0] active_cnt;

  // table contents as planned by the stimulus, ahead of the driver
  logic [7:0] plan_bytes [NUM_ENTRIES][PATH_MAX];
  logic [LEN_W-1:0] plan_len [NUM_ENTRIES];
  logic [7:0] path_buf [$];

  int unsigned n_queued, n_taken, n_verdicts, n_denies, n_fail, n_settings;
  int gap_left, quiet_cycles;
  bit idle_on = 1'b1;    // sender gaps allowed
  bit mix_loads = 1'b0;  // stray table loads inside a streamed path

  // ---------------------------------------------------------------------------
  // verdict prediction for one taken beat
  // ---------------------------------------------------------------------------
  task automatic verdict_step(input epdm_in_t it);
    int unsigned cur, lim;
    epdm_out_t v;
    case (it.action)
      ACT_WRITE_BYTE: begin
        // slots past the last byte are dropped
        if (it.byte_position < PATH_MAX)
          pat_mem[it.entry_index][it.byte_position] = it.byte_value;
      end
      ACT_SET_LEN: begin
        pat_len[it.entry_index] = it.pattern_length;
      end
      ACT_PROBE: begin
        cur = path_pos;
        // bytes past the compare window are not compared, position saturates
        if (cur < PATH_MAX)
          for (int e = 0; e < NUM_ENTRIES; e++)
            if (pat_mem[e][cur] != it.byte_value) miss_flags[e] = 1'b1;
        path_pos = (cur < PATH_MAX) ? cur + 1 : PATH_MAX;
        if (it.path_last) begin
          // count above the table size acts as the full table
          lim = (active_cnt > NUM_ENTRIES) ? NUM_ENTRIES : active_cnt;
          v = '0;
          // a path of PATH_MAX bytes or more stands for a failed lookup
          if (cur + 1 <= PATH_MAX - 1)
            for (int e = 0; e < lim; e++)
              if (!v.deny && pat_len[e] >= 1 && pat_len[e] <= PATH_MAX - 1 &&
                  pat_len[e] == cur + 1 && !miss_flags[e]) begin
                v.deny = 1'b1;
                v.match_index = IDX_W'(e);
              end
          verdict_q.push_back(v);
          miss_flags = '0;
          path_pos = 0;
        end
      end
      default: ;  // unused action code, nothing happens
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: one beat offered at a time, random gap bursts between beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        verdict_step(in_data);
        n_taken++;
      end
      // a beat held off by busy stays on the bus untouched
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (beat_q.size() > 0) begin
          in_data <= beat_q.pop_front();
          start <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 19);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every verdict is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    epdm_out_t want;
    if (rst_n && out_valid) begin
      n_verdicts++;
      if (out_data.deny === 1'b1) n_denies++;
      if (verdict_q.size() == 0) begin
        $error("verdict with none predicted: deny %0d match_index %0d",
               out_data.deny, out_data.match_index);
        n_fail++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.deny !== want.deny) begin
          $error("deny: expected %0d, got %0d", want.deny, out_data.deny);
          n_fail++;
        end
        if (out_data.match_index !== want.match_index) begin
          $error("match_index: expected %0d, got %0d", want.match_index,
                 out_data.match_index);
          n_fail++;
        end
      end
    end
  end

  // watchdog on handshake activity of any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no handshake for %0d cycles, %0d verdicts outstanding", STALL_LIMIT,
               verdict_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus building blocks
  // ---------------------------------------------------------------------------
  // random filler for the fields a beat does not use
  function automatic epdm_in_t noise_fields();
    logic [31:0] rnd;
    logic [$bits(epdm_in_t)-1:0] raw;
    rnd = $urandom;
    raw = rnd[$bits(epdm_in_t)-1:0];
    return raw;
  endfunction

  function automatic void queue_beat(input epdm_in_t it);
    beat_q.push_back(it);
    n_queued++;
    if (it.action == ACT_WRITE_BYTE && it.byte_position < PATH_MAX)
      plan_bytes[it.entry_index][it.byte_position] = it.byte_value;
    else if (it.action == ACT_SET_LEN)
      plan_len[it.entry_index] = it.pattern_length;
  endfunction

  function automatic void put_byte(input int unsigned e, input int unsigned p,
                                   input logic [7:0] v);
    epdm_in_t it;
    it = noise_fields();
    it.action = ACT_WRITE_BYTE;
    it.entry_index = IDX_W'(e);
    it.byte_position = 7'(p);
    it.byte_value = v;
    queue_beat(it);
  endfunction

  function automatic void put_len(input int unsigned e, input int unsigned l);
    epdm_in_t it;
    it = noise_fields();
    it.action = ACT_SET_LEN;
    it.entry_index = IDX_W'(e);
    it.pattern_length = LEN_W'(l);
    queue_beat(it);
  endfunction

  // sends path_buf as one probe; with mix_loads set, an occasional load slips in between bytes
  function automatic void stream_path();
    epdm_in_t it;
    for (int i = 0; i < path_buf.size(); i++) begin
      if (mix_loads && $urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1))
          put_byte($urandom_range(0, NUM_ENTRIES - 1), $urandom_range(0, PATH_MAX - 1),
                   8'($urandom));
        else
          put_len($urandom_range(0, NUM_ENTRIES - 1), $urandom_range(1, 8));
      end
      it = noise_fields();
      it.action = ACT_PROBE;
      it.byte_value = path_buf[i];
      it.path_last = (i == path_buf.size() - 1);
      queue_beat(it);
    end
  endfunction

  // mostly short patterns, now and then long ones and the longest valid
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 93) return $urandom_range(7, 24);
    if (r < 97) return PATH_MAX - 1;
    return $urandom_range(25, PATH_MAX - 2);
  endfunction

  // path_buf gets the planned pattern of entry e; invalid lengths give a
  // one-byte or an over-long path
  function automatic void load_pattern_path(input int unsigned e);
    int unsigned l;
    l = plan_len[e];
    if (l == 0) l = 1;
    else if (l >= PATH_MAX) l = PATH_MAX + $urandom_range(0, 3);
    path_buf.delete();
    for (int i = 0; i < l; i++)
      path_buf.push_back((i < PATH_MAX) ? plan_bytes[e][i] : 8'($urandom));
  endfunction

  // src of -1 means fresh random bytes, else a copy of another entry
  function automatic void program_entry(input int unsigned e, input int unsigned l,
                                        input int src);
    for (int i = 0; i < l && i < PATH_MAX; i++)
      put_byte(e, i, (src < 0) ? 8'($urandom) : plan_bytes[src][i]);
    put_len(e, l);
  endfunction

  function automatic void add_sequence();
    int unsigned pick, e, e2, n;
    epdm_in_t it;
    pick = $urandom_range(0, 99);
    e = $urandom_range(0, NUM_ENTRIES - 1);
    if (pick < 40) begin
      // exact hit attempt
      load_pattern_path(e);
      stream_path();
    end else if (pick < 58) begin
      program_entry(e, pick_len(), -1);
    end else if (pick < 63) begin
      // duplicate pattern, the lower index has to win
      e2 = $urandom_range(0, NUM_ENTRIES - 1);
      program_entry(e2, plan_len[e], int'(e));
      load_pattern_path(e);
      stream_path();
    end else if (pick < 78) begin
      // near miss: one byte off, one byte too many or too few
      load_pattern_path(e);
      case ($urandom_range(0, 2))
        0: begin
          n = $urandom_range(0, path_buf.size() - 1);
          path_buf[n] = path_buf[n] ^ 8'($urandom_range(1, 255));
        end
        1: path_buf.push_back(8'($urandom));
        default: begin
          if (path_buf.size() > 1) void'(path_buf.pop_back());
          else path_buf.push_back(8'($urandom));
        end
      endcase
      stream_path();
    end else if (pick < 88) begin
      path_buf.delete();
      n = $urandom_range(1, 5);
      repeat (n) path_buf.push_back(8'($urandom));
      stream_path();
    end else if (pick < 91) begin
      // over-long path, pattern bytes up front
      load_pattern_path(e);
      while (path_buf.size() < PATH_MAX + $urandom_range(0, 4))
        path_buf.push_back(8'($urandom));
      stream_path();
    end else begin
      // noise: unused action, dropped byte slots, any length at all
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: begin
            it = noise_fields();
            it.action = ACT_UNUSED;
            queue_beat(it);
          end
          1: put_byte(e, $urandom_range(PATH_MAX, 127), 8'($urandom));
          default: put_len(e, $urandom_range(0, 127));
        endcase
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // phase control
  // ---------------------------------------------------------------------------
  // every beat taken and every verdict seen, then a settling wait of SETTLE_CYCLES
  task automatic drain();
    while (n_taken != n_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_count(input int unsigned cnt);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= CFG_W'(cnt);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    active_cnt = CFG_W'(cnt);
    n_settings++;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned cnt, input int unsigned budget);
    int unsigned mark;
    set_active_count(cnt);
    mark = n_queued;
    while (n_queued - mark < budget) add_sequence();
    drain();
  endtask

  initial begin
    epdm_in_t it;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      pat_len[e] = '0;
      plan_len[e] = '0;
    end
    miss_flags = '0;
    path_pos = 0;
    active_cnt = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // bring-up under the reset count of zero: every bank byte gets a value so
    // no probe ever reads an unwritten slot; hits must still be refused
    for (int e = 0; e < NUM_ENTRIES; e++)
      for (int p = 0; p < PATH_MAX; p++) put_byte(e, p, 8'($urandom));
    for (int e = 0; e < NUM_ENTRIES; e++) put_len(e, pick_len());
    for (int e = 0; e < 4; e++) begin
      load_pattern_path(e);
      stream_path();
    end
    drain();

    // directed corners with the whole table active
    set_active_count(NUM_ENTRIES);
    it = '1;
    it.action = ACT_UNUSED;   // ignored, all other fields at ones
    queue_beat(it);
    put_byte(15, 127, 8'hFF); // byte slots beyond the pattern area are dropped
    put_byte(0, PATH_MAX, 8'hA5);
    put_len(14, 0);           // lengths that can never match
    put_len(15, 127);
    put_len(13, PATH_MAX);
    // single zero byte, duplicated higher up so the lowest entry wins
    put_byte(0, 0, 8'h00);
    put_len(0, 1);
    put_byte(3, 0, 8'h00);
    put_len(3, 1);
    path_buf = {8'h00};
    stream_path();
    // extreme byte values, then a prefix and an extension of the same path
    put_byte(1, 0, 8'hFF);
    put_byte(1, 1, 8'h00);
    put_len(1, 2);
    path_buf = {8'hFF, 8'h00};
    stream_path();
    path_buf = {8'hFF};
    stream_path();
    path_buf = {8'hFF, 8'h00, 8'h00};
    stream_path();
    // zero-length entry whose first byte agrees
    path_buf = {plan_bytes[14][0]};
    stream_path();
    // longest valid pattern, then one byte more, then well past the window
    put_len(12, PATH_MAX - 1);
    load_pattern_path(12);
    stream_path();
    path_buf.push_back(plan_bytes[12][PATH_MAX - 1]);
    stream_path();
    repeat (4) path_buf.push_back(8'($urandom));
    stream_path();
    drain();

    // random traffic over several table sizes, the extremes among them
    mix_loads = 1'b1;
    run_phase(0, 90);
    run_phase(31, 100);
    run_phase(1, 90);
    run_phase($urandom_range(2, NUM_ENTRIES - 1), 100);
    run_phase(NUM_ENTRIES + 1, 90);
    // closing stretch back to back
    idle_on = 1'b0;
    run_phase(NUM_ENTRIES, 130);

    $display("drove %0d beats over %0d table sizes", n_taken, n_settings);
    $display("checked %0d verdicts, %0d of them denies", n_verdicts, n_denies);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
